/* hdl/cssc_pkg.sv */
// Shared constants and digit helpers for the seven-segment clock scanner.
package cssc_pkg;

	localparam int DIGIT_COUNT = 4;
	localparam int DIGIT_W     = $clog2(DIGIT_COUNT);

	localparam int TICKS_W = 16;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int SEG_W   = 7;
	localparam int CFG_IDX_W = 3;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_PERIOD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_PERIOD   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_HOUR    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_MINUTE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_START_SECOND  = 3'd5;

	// reset values of the registers
	localparam logic [TICKS_W-1:0] RST_SECOND_PERIOD = 16'd100;
	localparam logic [TICKS_W-1:0] RST_SCAN_PERIOD   = 16'd25;
	localparam logic [TICKS_W-1:0] RST_FIRST_DELAY   = 16'd25;
	localparam logic [HOUR_W-1:0]  RST_START_HOUR    = 5'd22;
	localparam logic [MIN_W-1:0]   RST_START_MINUTE  = 6'd59;
	localparam logic [SEC_W-1:0]   RST_START_SECOND  = 6'd55;

	localparam logic [MIN_W-1:0]  MIN_WRAP  = 6'd60;
	localparam logic [SEC_W-1:0]  SEC_WRAP  = 6'd60;
	localparam logic [HOUR_W-1:0] HOUR_WRAP = 5'd24;

	localparam logic [SEG_W-1:0] SEG_BLANK = 7'h7F;

	// digit positions in scan order
	localparam logic [DIGIT_W-1:0] DIG_HOUR_TENS = 2'd0;
	localparam logic [DIGIT_W-1:0] DIG_HOUR_ONES = 2'd1;
	localparam logic [DIGIT_W-1:0] DIG_MIN_TENS  = 2'd2;
	localparam logic [DIGIT_W-1:0] DIG_MIN_ONES  = 2'd3;

	// tens digit of a six-bit count, by compare chain
	function automatic logic [3:0] tens_of(input logic [5:0] v);
		logic [3:0] t;
		if (v >= 6'd60)      t = 4'd6;
		else if (v >= 6'd50) t = 4'd5;
		else if (v >= 6'd40) t = 4'd4;
		else if (v >= 6'd30) t = 4'd3;
		else if (v >= 6'd20) t = 4'd2;
		else if (v >= 6'd10) t = 4'd1;
		else                 t = 4'd0;
		return t;
	endfunction

	function automatic logic [3:0] ones_of(input logic [5:0] v);
		logic [5:0] base;
		case (tens_of(v))
			4'd6: base = 6'd60;
			4'd5: base = 6'd50;
			4'd4: base = 6'd40;
			4'd3: base = 6'd30;
			4'd2: base = 6'd20;
			4'd1: base = 6'd10;
			default: base = 6'd0;
		endcase
		return 4'(v - base);
	endfunction

	// active-low a-g pattern, bit 0 is a
	function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 7'h40;
			4'd1: s = 7'h79;
			4'd2: s = 7'h24;
			4'd3: s = 7'h30;
			4'd4: s = 7'h19;
			4'd5: s = 7'h12;
			4'd6: s = 7'h02;
			4'd7: s = 7'h78;
			4'd8: s = 7'h00;
			4'd9: s = 7'h10;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

/* hdl/cssc_if.sv */
// Handshake channels of the scanner: tick input, display output, register writes.
interface cssc_tick_if;
	logic valid;
	logic ready;
	logic tick_pulse;

	modport source (output valid, output tick_pulse, input ready);
	modport sink   (input valid, input tick_pulse, output ready);
endinterface

interface cssc_disp_if;
	logic       valid;
	logic       ready;
	logic [3:0] digit_enables;
	logic [6:0] segments;
	logic       colon_dot;
	logic [4:0] hours_now;
	logic [5:0] minutes_now;
	logic [5:0] seconds_now;

	modport source (output valid, output digit_enables, output segments, output colon_dot,
		output hours_now, output minutes_now, output seconds_now, input ready);
	modport sink   (input valid, input digit_enables, input segments, input colon_dot,
		input hours_now, input minutes_now, input seconds_now, output ready);
endinterface

interface cssc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/cssc_digit_dec.sv */
// Digit select and seven-segment decode for one scan step.
module cssc_digit_dec (
	input  logic [cssc_pkg::DIGIT_W-1:0]     digit,
	input  logic [cssc_pkg::HOUR_W-1:0]      hours,
	input  logic [cssc_pkg::MIN_W-1:0]       minutes,
	output logic [cssc_pkg::DIGIT_COUNT-1:0] enables,
	output logic [cssc_pkg::SEG_W-1:0]       segments
);
	import cssc_pkg::*;

	logic [5:0] hours_ext;
	logic [3:0] value;

	assign hours_ext = {1'b0, hours};

	always_comb begin
		case (digit)
			DIG_HOUR_TENS: value = tens_of(hours_ext);
			DIG_HOUR_ONES: value = ones_of(hours_ext);
			DIG_MIN_TENS:  value = tens_of(minutes);
			DIG_MIN_ONES:  value = ones_of(minutes);
			default:       value = ones_of(minutes);
		endcase
	end

	assign enables  = ~(DIGIT_COUNT'(1) << digit);
	assign segments = seg_of(value);

endmodule

/* hdl/clock_seven_segment_scanner.sv */
// Top level of the multiplexed seven-segment clock scanner.
//
// Usage: every word on the tick channel is one step. tick_pulse = 1 means one
// base tick elapsed; 0 steps without time passing. Each step returns exactly
// one word on the disp channel: the digit enables and a-g segments being
// driven (both active low), the colon dot level and the current time.
// Two countdowns run off the ticks: one advances the clock (seconds, minutes,
// hours wrap at 60/60/24 and toggle the dot), the other steps the scan over
// hour tens, hour ones, minute tens, minute ones. Both first expire after
// first_delay_ticks, then reload from their own periods.
// The display word for an accepted tick word is registered and appears in the cycle after.
// Throughput: one word per cycle while disp.ready is high, set by the single output register; a new
// tick word is taken whenever that register is empty or being emptied.
// Stall: while disp.ready is low and a word waits, tick.ready is low.
// Reset: registers take their default values, the time loads from the start
// registers, enables and segments read all low until the first scan step.
// cfg: register writes are always taken; write only while the block is idle.
module clock_seven_segment_scanner (
	input logic clk,
	input logic arst_n,
	cssc_tick_if.sink   tick,
	cssc_disp_if.source disp,
	cssc_cfg_if.sink    cfg
);
	import cssc_pkg::*;

	// configuration registers; first delay only reloads the countdowns when written
	logic [TICKS_W-1:0] second_period_q, scan_period_q;

	// clock state
	logic [TICKS_W-1:0]     sec_cnt_q, scan_cnt_q;
	logic [HOUR_W-1:0]      hour_q;
	logic [MIN_W-1:0]       minute_q;
	logic [SEC_W-1:0]       second_q;
	logic [DIGIT_W-1:0]     digit_q;
	logic [DIGIT_COUNT-1:0] enables_q;
	logic [SEG_W-1:0]       segments_q;
	logic                   dot_q;

	// output word register
	logic                   out_vld_q;
	logic [DIGIT_COUNT-1:0] out_en_q;
	logic [SEG_W-1:0]       out_seg_q;
	logic                   out_dot_q;
	logic [HOUR_W-1:0]      out_hour_q;
	logic [MIN_W-1:0]       out_min_q;
	logic [SEC_W-1:0]       out_sec_q;

	logic in_acc, cfg_acc;
	logic step;

	// next-state for this tick
	logic [TICKS_W-1:0]     sec_cnt_nx, scan_cnt_nx;
	logic                   adv, scan;
	logic [SEC_W:0]         sec_inc;
	logic [MIN_W:0]         min_inc;
	logic [HOUR_W:0]        hour_inc;
	logic                   sec_wrap, min_wrap;
	logic [SEC_W-1:0]       second_nx;
	logic [MIN_W-1:0]       minute_nx;
	logic [HOUR_W-1:0]      hour_nx;
	logic                   dot_nx;
	logic [DIGIT_W-1:0]     digit_nx;
	logic [DIGIT_COUNT-1:0] dec_en, enables_nx;
	logic [SEG_W-1:0]       dec_seg, segments_nx;

	assign tick.ready = !out_vld_q || disp.ready;
	assign in_acc     = tick.valid && tick.ready;
	assign cfg.ready  = 1'b1;
	assign cfg_acc    = cfg.valid;
	assign step       = in_acc && tick.tick_pulse;

	// countdowns: stopped at zero, expire on reaching zero and reload
	always_comb begin
		adv  = (sec_cnt_q == TICKS_W'(1));
		scan = (scan_cnt_q == TICKS_W'(1));
		if (sec_cnt_q == '0)  sec_cnt_nx = '0;
		else if (adv)         sec_cnt_nx = second_period_q;
		else                  sec_cnt_nx = sec_cnt_q - TICKS_W'(1);
		if (scan_cnt_q == '0) scan_cnt_nx = '0;
		else if (scan)        scan_cnt_nx = scan_period_q;
		else                  scan_cnt_nx = scan_cnt_q - TICKS_W'(1);
	end

	// time advance; out-of-range counts wrap on the next advance
	always_comb begin
		sec_inc  = {1'b0, second_q} + (SEC_W+1)'(1);
		sec_wrap = sec_inc >= {1'b0, SEC_WRAP};
		min_inc  = {1'b0, minute_q} + (MIN_W+1)'(sec_wrap);
		min_wrap = min_inc >= {1'b0, MIN_WRAP};
		hour_inc = {1'b0, hour_q} + (HOUR_W+1)'(min_wrap);
		if (adv) begin
			second_nx = sec_wrap ? '0 : sec_inc[SEC_W-1:0];
			minute_nx = min_wrap ? '0 : min_inc[MIN_W-1:0];
			hour_nx   = (hour_inc >= {1'b0, HOUR_WRAP}) ? '0 : hour_inc[HOUR_W-1:0];
			dot_nx    = !dot_q;
		end else begin
			second_nx = second_q;
			minute_nx = minute_q;
			hour_nx   = hour_q;
			dot_nx    = dot_q;
		end
	end

	// scan shows the time after this tick's advance
	cssc_digit_dec u_dec (
		.digit    (digit_q),
		.hours    (hour_nx),
		.minutes  (minute_nx),
		.enables  (dec_en),
		.segments (dec_seg)
	);

	assign enables_nx  = scan ? dec_en : enables_q;
	assign segments_nx = scan ? dec_seg : segments_q;
	assign digit_nx    = scan ? digit_q + DIGIT_W'(1) : digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_period_q <= RST_SECOND_PERIOD;
			scan_period_q   <= RST_SCAN_PERIOD;
			sec_cnt_q       <= RST_FIRST_DELAY;
			scan_cnt_q      <= RST_FIRST_DELAY;
			hour_q          <= RST_START_HOUR;
			minute_q        <= RST_START_MINUTE;
			second_q        <= RST_START_SECOND;
			digit_q         <= '0;
			enables_q       <= '0;
			segments_q      <= '0;
			dot_q           <= 1'b1;
		end else if (cfg_acc) begin
			case (cfg.index)
				REG_SECOND_PERIOD: second_period_q <= cfg.data;
				REG_SCAN_PERIOD:   scan_period_q   <= cfg.data;
				REG_FIRST_DELAY: begin
					sec_cnt_q  <= cfg.data;
					scan_cnt_q <= cfg.data;
				end
				REG_START_HOUR:    hour_q   <= cfg.data[HOUR_W-1:0];
				REG_START_MINUTE:  minute_q <= cfg.data[MIN_W-1:0];
				REG_START_SECOND:  second_q <= cfg.data[SEC_W-1:0];
				default: ;
			endcase
		end else if (step) begin
			sec_cnt_q  <= sec_cnt_nx;
			scan_cnt_q <= scan_cnt_nx;
			hour_q     <= hour_nx;
			minute_q   <= minute_nx;
			second_q   <= second_nx;
			dot_q      <= dot_nx;
			digit_q    <= digit_nx;
			enables_q  <= enables_nx;
			segments_q <= segments_nx;
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (tick.ready) begin
			out_vld_q <= tick.valid;
		end
	end

	// output word payload: state after the step
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (tick.tick_pulse) begin
				out_en_q   <= enables_nx;
				out_seg_q  <= segments_nx;
				out_dot_q  <= dot_nx;
				out_hour_q <= hour_nx;
				out_min_q  <= minute_nx;
				out_sec_q  <= second_nx;
			end else begin
				out_en_q   <= enables_q;
				out_seg_q  <= segments_q;
				out_dot_q  <= dot_q;
				out_hour_q <= hour_q;
				out_min_q  <= minute_q;
				out_sec_q  <= second_q;
			end
		end
	end

	assign disp.valid         = out_vld_q;
	assign disp.digit_enables = out_en_q;
	assign disp.segments      = out_seg_q;
	assign disp.colon_dot     = out_dot_q;
	assign disp.hours_now     = out_hour_q;
	assign disp.minutes_now   = out_min_q;
	assign disp.seconds_now   = out_sec_q;

endmodule
